// File: design/hdfm_pkg.sv
// Shared types and constants for the hashed dither fade mask.
// Holds the coordinate width, hash multipliers and configuration register indexes.
// Used by hdfm_coord_if, by hashed_dither_fade_mask_core and by its testbench.
package hdfm_pkg;

  // Width of a pixel coordinate and of the fade column registers.
  localparam int COORD_BITS = 12;

  // Width of the dither threshold taken from the hash.
  localparam int NOISE_BITS = 24;

  // Width of both sides of the coverage comparison.
  localparam int PROD_W = COORD_BITS + NOISE_BITS;

  // Multipliers of the coordinate hash.
  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

  // Configuration register indexes, taken from paddr[3:2].
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_PANEL_COLOR = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FADE_START  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FADE_END    = 2'd2;

  // APB address and data widths.
  localparam int ADDR_W = REG_IDX_W + 2;
  localparam int DATA_W = 32;

  typedef logic [COORD_BITS-1:0] coord_t;

endpackage

// File: design/hdfm_coord_if.sv
// Valid/ready channel that carries one pixel coordinate per transaction.
// Depends on hdfm_pkg for the coordinate type.
interface hdfm_coord_if;
  logic              valid;
  logic              ready;
  hdfm_pkg::coord_t  column;
  hdfm_pkg::coord_t  row;

  modport source (output valid, output column, output row, input ready);
  modport sink (input valid, input column, input row, output ready);
endinterface

// File: design/hdfm_result_if.sv
// Valid/ready channel that carries one overlay pixel per transaction.
// Stands alone; the pixel is a 32-bit premultiplied ARGB word.
interface hdfm_result_if;
  logic        valid;
  logic        ready;
  logic        covered;
  logic [31:0] pixel;

  modport source (output valid, output covered, output pixel, input ready);
  modport sink (input valid, input covered, input pixel, output ready);
endinterface

// File: design/hashed_dither_fade_mask_core.sv
// Top level of the hashed dither fade mask: a five-stage pixel pipeline.
// Depends on hdfm_pkg, hdfm_coord_if and hdfm_result_if.
//
// Usage:
//   coord  : sink channel, one (column, row) pixel coordinate per transaction.
//   result : source channel, one (covered, pixel) per coordinate, in order.
//   APB    : panel_color at 0x0, fade_start at 0x4, fade_end at 0x8; pready is
//            always high and writes land on the access cycle. Registers must
//            be written only while the pipeline is empty; the core does not
//            enforce this.
// Each coordinate passes five register stages: the coordinate multiplies, the
// product sum with the first fold, the mixing multiply, the final fold with the
// threshold times span multiply, and the output register. Throughput is one
// pixel per cycle while result.ready stays high, since every stage can then
// take a new item in each cycle. Each stage holds its item while the stage
// after it is full and stalled, and takes a new one as soon as it moves on, so
// a stall on the result side loses and repeats nothing; coord.ready falls only
// when all five stages are full. Reset (rst, synchronous, active high) empties
// the pipeline and clears the three configuration registers to zero.
module hashed_dither_fade_mask_core (
  input  logic                         clk,
  input  logic                         rst,
  hdfm_coord_if.sink                   coord,
  hdfm_result_if.source                result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hdfm_pkg::ADDR_W-1:0]  paddr,
  input  logic [hdfm_pkg::DATA_W-1:0]  pwdata,
  output logic [hdfm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int CB = hdfm_pkg::COORD_BITS;
  localparam int NB = hdfm_pkg::NOISE_BITS;
  localparam int PW = hdfm_pkg::PROD_W;

  // Configuration registers.
  logic [31:0]      panel_color;
  hdfm_pkg::coord_t fade_start;
  hdfm_pkg::coord_t fade_end;
  logic [hdfm_pkg::REG_IDX_W-1:0] reg_idx;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[hdfm_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Register writes; an address beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_color <= '0;
      fade_start  <= '0;
      fade_end    <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        hdfm_pkg::REG_PANEL_COLOR: panel_color <= pwdata[31:0];
        hdfm_pkg::REG_FADE_START:  fade_start  <= pwdata[CB-1:0];
        hdfm_pkg::REG_FADE_END:    fade_end    <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      hdfm_pkg::REG_PANEL_COLOR: prdata = panel_color;
      hdfm_pkg::REG_FADE_START:  prdata = hdfm_pkg::DATA_W'(fade_start);
      hdfm_pkg::REG_FADE_END:    prdata = hdfm_pkg::DATA_W'(fade_end);
      default:                   prdata = '0;
    endcase
  end

  // Stage valid bits and advance enables; a stage loads when it is empty or
  // its content moves on in the same cycle.
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || result.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign coord.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= coord.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 1: coordinate products and the fade geometry.
  // end - column equals span - d whenever the column lies inside the fade.
  logic [31:0] px1, py1;
  logic        full1, none1;
  logic [CB-1:0] rem1, span1;

  always_ff @(posedge clk) begin
    if (en1) begin
      px1   <= 32'(coord.column) * hdfm_pkg::HASH_MUL_X;
      py1   <= 32'(coord.row) * hdfm_pkg::HASH_MUL_Y;
      full1 <= coord.column <= fade_start;
      none1 <= coord.column >= fade_end;
      rem1  <= fade_end - coord.column;
      span1 <= fade_end - fade_start;
    end
  end

  // Stage 2: sum of the products and the first xor-shift fold.
  logic [31:0] sum1;
  logic [31:0] fold2;
  logic        full2, none2;
  logic [CB-1:0] rem2, span2;

  assign sum1 = px1 + py1;

  always_ff @(posedge clk) begin
    if (en2) begin
      fold2 <= sum1 ^ (sum1 >> 13);
      full2 <= full1;
      none2 <= none1;
      rem2  <= rem1;
      span2 <= span1;
    end
  end

  // Stage 3: mixing multiply, low 32 bits kept.
  logic [31:0] mix3;
  logic        full3, none3;
  logic [CB-1:0] rem3, span3;

  always_ff @(posedge clk) begin
    if (en3) begin
      mix3  <= fold2 * hdfm_pkg::HASH_MUL_MIX;
      full3 <= full2;
      none3 <= none2;
      rem3  <= rem2;
      span3 <= span2;
    end
  end

  // Stage 4: final fold to the 24-bit threshold and its product with the span.
  logic [31:0]   hash3;
  logic [NB-1:0] thresh3;
  logic [PW-1:0] lhs4, rhs4;
  logic          full4, none4;

  assign hash3   = mix3 ^ (mix3 >> 16);
  assign thresh3 = hash3[NB-1:0];

  always_ff @(posedge clk) begin
    if (en4) begin
      rhs4  <= PW'(thresh3) * PW'(span3);
      lhs4  <= {rem3, {NB{1'b0}}};
      full4 <= full3;
      none4 <= none3;
    end
  end

  // Stage 5: coverage decision and the output register.
  logic cov4;

  assign cov4 = full4 || (!none4 && (lhs4 > rhs4));

  always_ff @(posedge clk) begin
    if (en5) begin
      result.covered <= cov4;
      result.pixel   <= cov4 ? panel_color : 32'd0;
    end
  end

  assign result.valid = v5;

  // A transparent result carries zero.
  a_transparent_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.covered) |-> (result.pixel == 32'd0))
    else $error("uncovered pixel is not zero");

  // The input side stalls only when every stage holds an item.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !coord.ready |-> (v1 && v2 && v3 && v4 && v5))
    else $error("input stalled with an empty stage");

  // A held item in stage four is still there next cycle.
  a_stage4_holds: assert property (@(posedge clk) disable iff (rst)
    (v4 && !en4) |=> v4)
    else $error("held item lost from stage four");

endmodule

// File: dv/tb_hashed_dither_fade_mask_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for hashed_dither_fade_mask_core: drives pixel coordinates and
// register writes, predicts each overlay pixel in-line and checks every result in order.
// Depends on hdfm_pkg, hdfm_coord_if, hdfm_result_if and the core itself.
module tb_hashed_dither_fade_mask_core;

  localparam int PIPE_LATENCY = 5;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [hdfm_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic        covered;
    logic [31:0] pixel;
  } overlay_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [hdfm_pkg::ADDR_W-1:0] paddr;
  logic [hdfm_pkg::DATA_W-1:0] pwdata;
  logic [hdfm_pkg::DATA_W-1:0] prdata;
  logic pready;

  hdfm_coord_if  coord ();
  hdfm_result_if result ();

  hashed_dither_fade_mask_core uut (
    .clk     (clk),
    .rst     (rst),
    .coord   (coord),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copies of the configuration registers.
  logic [31:0]      panel_color_q;
  hdfm_pkg::coord_t fade_start_q;
  hdfm_pkg::coord_t fade_end_q;

  overlay_t expected_pixels[$];
  int mismatch_count;
  int cycle_count;
  int src_idle_pct;
  int snk_stall_pct;
  int hold_request;
  int hold_left;

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Coordinate hash: two multiplies, an xor-shift fold, the mixing multiply and a final fold.
  function automatic logic [31:0] dither_hash(input hdfm_pkg::coord_t x,
                                              input hdfm_pkg::coord_t y);
    logic [31:0] h;
    h = {20'd0, x} * hdfm_pkg::HASH_MUL_X + {20'd0, y} * hdfm_pkg::HASH_MUL_Y;
    h = (h ^ (h >> 13)) * hdfm_pkg::HASH_MUL_MIX;
    return h ^ (h >> 16);
  endfunction

  // Coverage decision, exact in integers: (span - d) * 2^24 > threshold * span.
  function automatic logic pixel_is_covered(input hdfm_pkg::coord_t x,
                                            input hdfm_pkg::coord_t y);
    logic [31:0] h;
    logic [63:0] lhs;
    logic [63:0] rhs;
    hdfm_pkg::coord_t span;
    hdfm_pkg::coord_t dcol;
    if (x <= fade_start_q) return 1'b1;
    if (x >= fade_end_q) return 1'b0;
    span = fade_end_q - fade_start_q;
    dcol = x - fade_start_q;
    h = dither_hash(x, y);
    lhs = {52'd0, hdfm_pkg::coord_t'(span - dcol)} << hdfm_pkg::NOISE_BITS;
    rhs = {40'd0, h[hdfm_pkg::NOISE_BITS-1:0]} * {52'd0, span};
    return lhs > rhs;
  endfunction

  // One APB write: setup cycle, then access cycle until pready, then an idle
  // cycle in which the register is read back.
  task automatic write_reg(input logic [hdfm_pkg::REG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    logic [hdfm_pkg::DATA_W-1:0] want_rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      hdfm_pkg::REG_PANEL_COLOR: begin
        panel_color_q = value;
        want_rd       = value;
      end
      hdfm_pkg::REG_FADE_START: begin
        fade_start_q = value[hdfm_pkg::COORD_BITS-1:0];
        want_rd      = hdfm_pkg::DATA_W'(fade_start_q);
      end
      hdfm_pkg::REG_FADE_END: begin
        fade_end_q = value[hdfm_pkg::COORD_BITS-1:0];
        want_rd    = hdfm_pkg::DATA_W'(fade_end_q);
      end
      default: want_rd = '0;
    endcase
    @(posedge clk);
    if (prdata !== want_rd) begin
      $display("%0t: read-back expected %08h actual %08h", $time, want_rd, prdata);
      mismatch_count++;
    end
  endtask

  // Offers one coordinate, with random idle cycles ahead of it, and records the
  // predicted pixel once the transaction completes. Valid stays high on return.
  task automatic send_coord(input hdfm_pkg::coord_t col, input hdfm_pkg::coord_t rw);
    overlay_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      coord.valid <= 1'b0;
      @(posedge clk);
    end
    coord.valid  <= 1'b1;
    coord.column <= col;
    coord.row    <= rw;
    do @(posedge clk); while (!coord.ready);
    want.covered = pixel_is_covered(col, rw);
    want.pixel   = want.covered ? panel_color_q : 32'h0;
    expected_pixels.push_back(want);
  endtask

  // Stops offering coordinates and waits until every predicted pixel has come back.
  task automatic drain_pixels();
    coord.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  task automatic load_fade(input logic [31:0] color, input logic [31:0] start_w,
                           input logic [31:0] end_w);
    write_reg(hdfm_pkg::REG_PANEL_COLOR, color);
    write_reg(hdfm_pkg::REG_FADE_START, start_w);
    write_reg(hdfm_pkg::REG_FADE_END, end_w);
  endtask

  // Most columns land inside the fade, where the dither decision is made.
  function automatic hdfm_pkg::coord_t pick_column();
    if (fade_start_q < fade_end_q && $urandom_range(99) < 65)
      return hdfm_pkg::coord_t'($urandom_range(fade_end_q, fade_start_q));
    return hdfm_pkg::coord_t'($urandom());
  endfunction

  // Registers straight out of reset: only column zero is covered, in colour zero.
  task automatic test_reset_defaults();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_coord(12'd0, 12'd0);
    send_coord(12'd1, 12'd9);
    send_coord(12'hfff, 12'hfff);
    drain_pixels();
  endtask

  // Field extremes, the fade boundaries, an inverted fade and an ignored register.
  task automatic test_directed_edges();
    // Upper pwdata bits must be dropped by the fade registers.
    load_fade(32'hA5C3_5A3C, 32'hFFFF_F064, 32'h0000_012C);
    write_reg(REG_UNUSED, 32'h1234_5678);
    send_coord(12'd0, 12'd0);
    send_coord(12'hfff, 12'hfff);
    send_coord(12'd100, 12'd0);
    send_coord(12'd100, 12'hfff);
    send_coord(12'd101, 12'd7);
    send_coord(12'd200, 12'd123);
    send_coord(12'd299, 12'hfff);
    send_coord(12'd300, 12'd0);
    send_coord(12'd301, 12'd55);
    send_coord(12'hfff, 12'd0);
    drain_pixels();
    // End before start: a hard edge just after the start column.
    load_fade(32'hFFFF_FFFF, 32'd200, 32'd50);
    send_coord(12'd50, 12'd3);
    send_coord(12'd199, 12'd800);
    send_coord(12'd200, 12'd1);
    send_coord(12'd201, 12'd2);
    drain_pixels();
    // Start and end both at the last column: everything is covered.
    load_fade(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0FFF);
    send_coord(12'hfff, 12'hfff);
    send_coord(12'd0, 12'd0);
    send_coord(12'h800, 12'h555);
    drain_pixels();
  endtask

  // Random pixels under one fade setting and one idling pattern; now and then the
  // sender pauses until the pipeline has emptied.
  task automatic run_random_phase(input int n, input int src_pct, input int snk_pct,
                                  input logic [31:0] color, input logic [31:0] start_w,
                                  input logic [31:0] end_w);
    load_fade(color, start_w, end_w);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < n; i++) begin
      send_coord(pick_column(), hdfm_pkg::coord_t'($urandom()));
      if ($urandom_range(59) == 0) drain_pixels();
    end
    drain_pixels();
  endtask

  // The receiver holds off for a long stretch while coordinates keep coming, so the
  // pipeline fills and the input stalls.
  task automatic test_backpressure();
    load_fade($urandom(), 32'd1365, 32'd2730);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_request  = 60;
    for (int i = 0; i < 40; i++) send_coord(pick_column(), hdfm_pkg::coord_t'($urandom()));
    drain_pixels();
  endtask

  // Result-side ready, with random stalls and the occasional long hold-off.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Compares each completed result transaction with the oldest prediction.
  always @(posedge clk) begin
    overlay_t want;
    if (!rst && result.valid && result.ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result covered=%0b pixel=%08h", $time, result.covered,
                 result.pixel);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (result.covered !== want.covered) begin
          $display("%0t: covered expected %0b actual %0b", $time, want.covered,
                   result.covered);
          mismatch_count++;
        end
        if (result.pixel !== want.pixel) begin
          $display("%0t: pixel expected %08h actual %08h", $time, want.pixel, result.pixel);
          mismatch_count++;
        end
      end
    end
  end

  // Run-time limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    coord.valid    = 1'b0;
    coord.column   = '0;
    coord.row      = '0;
    result.ready   = 1'b0;
    panel_color_q  = 32'h0;
    fade_start_q   = '0;
    fade_end_q     = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    hold_request   = 0;
    hold_left      = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed_edges();
    run_random_phase(200, 0, 0, $urandom(), 32'd1365, 32'd2730);
    run_random_phase(150, 79, 0, 32'hFFFF_FFFF, 32'd0, 32'd4095);
    run_random_phase(120, 0, 79, $urandom(), 32'd3000, 32'd100);
    run_random_phase(150, 25, 25, $urandom(), {20'($urandom()), 12'($urandom_range(1500))},
                     {20'($urandom()), 12'($urandom_range(4095, 2000))});
    run_random_phase(60, 25, 25, 32'h0, 32'd4095, 32'd0);
    run_random_phase(60, 0, 0, $urandom(), 32'd0, 32'd1);
    test_backpressure();
    run_random_phase(100, 25, 25, $urandom(), 32'd4000, 32'd4095);

    drain_pixels();
    repeat (PIPE_LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
design/hdfm_pkg.sv
design/hdfm_coord_if.sv
design/hdfm_result_if.sv
design/hashed_dither_fade_mask_core.sv
dv/tb_hashed_dither_fade_mask_core.sv
